FILE: design/fbd_pkg.sv
// Package for the four-button debouncer: payload structs, register map,
// and the control structs passed between the top level and the button cells.
// No dependencies.
`timescale 1ns / 1ps

package fbd_pkg;

  // Number of buttons served (1 to 4)
  localparam int NUM_BUTTONS = 4;
  // Number of id registers in the map, independent of NUM_BUTTONS
  localparam int NUM_ID_REGS = 4;

  localparam int TIMER_W = 17;
  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

  // Configuration port geometry
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Register indexes (paddr[4:2])
  localparam logic [2:0] REG_DEBOUNCE   = 3'd0;
  localparam logic [2:0] REG_ACTIVE_LOW = 3'd1;
  localparam logic [2:0] REG_BUTTON_ID0 = 3'd2;
  localparam logic [2:0] REG_BUTTON_ID1 = 3'd3;
  localparam logic [2:0] REG_BUTTON_ID2 = 3'd4;
  localparam logic [2:0] REG_BUTTON_ID3 = 3'd5;

  // Reset values
  localparam logic [15:0] DEBOUNCE_RST   = 16'd20;
  localparam logic        ACTIVE_LOW_RST = 1'b1;

  // One poll tick
  typedef struct packed {
    logic [3:0] raw_levels;
    logic [7:0] tick_ms;
  } in_item_t;

  // One button event
  typedef struct packed {
    logic [7:0] event_id;
    logic       event_down;
    logic       event_last;
  } out_item_t;

  // Settings shared by every button cell
  typedef struct packed {
    logic [15:0] debounce_ms;
    logic        active_low;
  } btn_cfg_t;

  // Event flag from one button cell for the current tick
  typedef struct packed {
    logic fire;
    logic down;
  } btn_evt_t;

endpackage

FILE: design/four_button_debouncer.sv
// Top level of the four-button debouncer: APB register file, button cells
// and a two-slot event batch queue feeding the result channel.
// Depends on fbd_pkg and fbd_button.
`timescale 1ns / 1ps

//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in_     | in_valid, in_stall, in_data          | tick in
//  out_    | out_valid, out_stall, out_data       | event out
//  cfg_    | psel/penable/pwrite/paddr/pwdata/... | APB slave
//
// A tick is accepted in any cycle in which the second batch slot is free and
// updates all button state at that edge. Its events (0..4) go out one per
// cycle from the head batch slot while out_stall is low; a new tick can be
// accepted while the head batch is still draining.
// Synchronous active-low reset: all buttons released, timers zero.
// out_stall holds the head event; in_stall rises only when both slots hold.

module four_button_debouncer
  import fbd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  // ---------------- register file ----------------
  logic [15:0] debounce_r;
  logic        active_low_r;
  logic [7:0]  btn_id_r [NUM_ID_REGS];
  logic [2:0]  reg_idx;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RST;
      active_low_r <= ACTIVE_LOW_RST;
      for (int i = 0; i < NUM_ID_REGS; i++) begin
        btn_id_r[i] <= 8'(i);
      end
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_DEBOUNCE:   debounce_r   <= cfg_pwdata[15:0];
        REG_ACTIVE_LOW: active_low_r <= cfg_pwdata[0];
        REG_BUTTON_ID0: btn_id_r[0]  <= cfg_pwdata[7:0];
        REG_BUTTON_ID1: btn_id_r[1]  <= cfg_pwdata[7:0];
        REG_BUTTON_ID2: btn_id_r[2]  <= cfg_pwdata[7:0];
        REG_BUTTON_ID3: btn_id_r[3]  <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    unique case (reg_idx)
      REG_DEBOUNCE:   cfg_prdata = {16'd0, debounce_r};
      REG_ACTIVE_LOW: cfg_prdata = {31'd0, active_low_r};
      REG_BUTTON_ID0: cfg_prdata = {24'd0, btn_id_r[0]};
      REG_BUTTON_ID1: cfg_prdata = {24'd0, btn_id_r[1]};
      REG_BUTTON_ID2: cfg_prdata = {24'd0, btn_id_r[2]};
      REG_BUTTON_ID3: cfg_prdata = {24'd0, btn_id_r[3]};
      default:        cfg_prdata = '0;
    endcase
  end

  // ---------------- button cells ----------------
  btn_cfg_t               cell_cfg;
  btn_evt_t               evt [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] ev_mask;
  logic [NUM_BUTTONS-1:0] ev_down;
  logic                   in_fire;

  assign cell_cfg.debounce_ms = debounce_r;
  assign cell_cfg.active_low  = active_low_r;

  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_btn
    fbd_button u_btn (
      .clk     (clk),
      .rst_n   (rst_n),
      .step    (in_fire),
      .level   (in_data.raw_levels[g]),
      .tick_ms (in_data.tick_ms),
      .cfg     (cell_cfg),
      .evt     (evt[g])
    );
    assign ev_mask[g] = evt[g].fire;
    assign ev_down[g] = evt[g].down;
  end

  // ---------------- event batch queue ----------------
  logic                   v0_r, v0_nxt, v1_r, v1_nxt;
  logic [NUM_BUTTONS-1:0] m0_r, m0_nxt, m1_r, m1_nxt;
  logic [NUM_BUTTONS-1:0] d0_r, d0_nxt, d1_r, d1_nxt;
  logic [NUM_BUTTONS-1:0] head_oh;
  logic                   head_last;
  logic                   out_fire;
  logic                   pop;
  logic                   push;

  assign in_stall  = v1_r;
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = v0_r;
  assign out_fire  = out_valid && !out_stall;

  // Lowest pending button in the head batch goes first
  assign head_oh   = m0_r & (~m0_r + NUM_BUTTONS'(1));
  assign head_last = ((m0_r & ~head_oh) == '0);
  assign pop       = out_fire && head_last;
  assign push      = in_fire && (ev_mask != '0);

  always_comb begin
    v0_nxt = v0_r;
    m0_nxt = m0_r;
    d0_nxt = d0_r;
    v1_nxt = v1_r;
    m1_nxt = m1_r;
    d1_nxt = d1_r;
    // retire head event or whole batch
    if (pop) begin
      v0_nxt = v1_r;
      m0_nxt = m1_r;
      d0_nxt = d1_r;
      v1_nxt = 1'b0;
    end else if (out_fire) begin
      m0_nxt = m0_r & ~head_oh;
    end
    // new batch into first free slot
    if (push) begin
      if (!v0_nxt) begin
        v0_nxt = 1'b1;
        m0_nxt = ev_mask;
        d0_nxt = ev_down;
      end else begin
        v1_nxt = 1'b1;
        m1_nxt = ev_mask;
        d1_nxt = ev_down;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m0_r <= m0_nxt;
    d0_r <= d0_nxt;
    m1_r <= m1_nxt;
    d1_r <= d1_nxt;
  end

  // Result payload from the head slot
  always_comb begin
    out_data.event_id = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      out_data.event_id = out_data.event_id | (head_oh[i] ? btn_id_r[i] : 8'd0);
    end
    out_data.event_down = |(head_oh & d0_r);
    out_data.event_last = head_last;
  end

`ifndef NO_ASSERTIONS
  // A valid head batch always has at least one event left
  a_head_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    v0_r |-> (m0_r != '0))
    else $error("head batch valid with no events");

  // The second slot is only used behind a valid head
  a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> v0_r)
    else $error("second batch slot valid with empty head");

  // A stalled event keeps the same button selected
  a_head_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(head_oh)))
    else $error("stalled head event changed");
`endif

endmodule

FILE: design/fbd_button.sv
// Debounce cell for one button: previous level, stable state and timer.
// Depends on fbd_pkg.
`timescale 1ns / 1ps

module fbd_button
  import fbd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step,
  input  logic     level,
  input  logic [7:0] tick_ms,
  input  btn_cfg_t cfg,
  output btn_evt_t evt
);

  logic               prev_r, prev_nxt;
  logic               stable_r, stable_nxt;
  logic [TIMER_W-1:0] timer_r, timer_nxt;

  logic               down;
  logic               changed;
  logic               below;
  logic [TIMER_W:0]   t_sum;
  logic [TIMER_W-1:0] t_sat;
  logic               fire;

  // Level mapping and saturating timer add
  assign down    = level ^ cfg.active_low;
  assign changed = (down != prev_r);
  assign below   = (timer_r < TIMER_W'(cfg.debounce_ms));
  assign t_sum   = {1'b0, timer_r} + (TIMER_W+1)'(tick_ms);
  assign t_sat   = t_sum[TIMER_W] ? TIMER_MAX : t_sum[TIMER_W-1:0];
  assign fire    = step && !changed && below &&
                   (t_sat >= TIMER_W'(cfg.debounce_ms)) && (down != stable_r);

  assign evt.fire = fire;
  assign evt.down = down;

  // State update on each accepted tick
  always_comb begin
    prev_nxt   = prev_r;
    stable_nxt = stable_r;
    timer_nxt  = timer_r;
    if (step) begin
      if (changed) begin
        prev_nxt  = down;
        timer_nxt = '0;
      end else if (below) begin
        timer_nxt = t_sat;
      end
      if (fire) begin
        stable_nxt = down;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= 1'b0;
      stable_r <= 1'b0;
      timer_r  <= '0;
    end else begin
      prev_r   <= prev_nxt;
      stable_r <= stable_nxt;
      timer_r  <= timer_nxt;
    end
  end

endmodule

FILE: bench/four_button_debouncer_tb.sv
// Self-checking testbench for four_button_debouncer: poll-tick requests in,
// button events out, registers written over the APB-style port.
// Depends on fbd_pkg and the four_button_debouncer RTL.
`timescale 1ns / 1ps

module four_button_debouncer_tb
  import fbd_pkg::*;
();

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int SETTLE_CYCLES = 8;
  // Indexes past the end of the register map, which the block ignores
  localparam logic [2:0] REG_SPARE6 = 3'd6;
  localparam logic [2:0] REG_SPARE7 = 3'd7;

  // Tracks the debouncer state and the events each accepted tick must produce
  class debounce_checker;
    logic [15:0]        debounce_len;
    logic               low_active;
    logic [7:0]         ids [NUM_ID_REGS];
    logic               last_down [NUM_BUTTONS];
    logic               stable_down [NUM_BUTTONS];
    logic [TIMER_W-1:0] held_ms [NUM_BUTTONS];
    out_item_t          pending_events [$];
    int                 events_due;
    int                 events_seen;
    int                 mismatches;

    function new();
      debounce_len = DEBOUNCE_RST;
      low_active = ACTIVE_LOW_RST;
      for (int i = 0; i < NUM_ID_REGS; i++) ids[i] = 8'(i);
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        last_down[i] = 1'b0;
        stable_down[i] = 1'b0;
        held_ms[i] = '0;
      end
      events_due = 0;
      events_seen = 0;
      mismatches = 0;
    endfunction

    task report(string msg);
      mismatches++;
      $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_DEBOUNCE:   debounce_len = val[15:0];
        REG_ACTIVE_LOW: low_active = val[0];
        REG_BUTTON_ID0: ids[0] = val[7:0];
        REG_BUTTON_ID1: ids[1] = val[7:0];
        REG_BUTTON_ID2: ids[2] = val[7:0];
        REG_BUTTON_ID3: ids[3] = val[7:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(logic [2:0] idx);
      case (idx)
        REG_DEBOUNCE:   return {16'd0, debounce_len};
        REG_ACTIVE_LOW: return {31'd0, low_active};
        REG_BUTTON_ID0: return {24'd0, ids[0]};
        REG_BUTTON_ID1: return {24'd0, ids[1]};
        REG_BUTTON_ID2: return {24'd0, ids[2]};
        REG_BUTTON_ID3: return {24'd0, ids[3]};
        default:        return 32'd0;
      endcase
    endfunction

    // Raw levels that oppose the debounced state of every button
    function logic [3:0] flipped_levels();
      logic [3:0] lv;
      lv = '0;
      for (int i = 0; i < NUM_BUTTONS; i++) lv[i] = ~stable_down[i] ^ low_active;
      return lv;
    endfunction

    // Advance every button by one accepted tick and queue its events
    function void note_tick(in_item_t t);
      logic             down;
      logic [TIMER_W:0] sum;
      out_item_t        ev;
      int               first;
      first = pending_events.size();
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        down = t.raw_levels[i] ^ low_active;
        // any level change restarts the stable timer
        if (down != last_down[i]) begin
          last_down[i] = down;
          held_ms[i] = '0;
          continue;
        end
        if (held_ms[i] < debounce_len) begin
          sum = held_ms[i] + t.tick_ms;
          held_ms[i] = (sum > TIMER_MAX) ? TIMER_MAX : sum[TIMER_W-1:0];
          if (held_ms[i] >= debounce_len && down != stable_down[i]) begin
            stable_down[i] = down;
            ev.event_id = ids[i];
            ev.event_down = down;
            ev.event_last = 1'b0;
            pending_events.push_back(ev);
            events_due++;
          end
        end
      end
      if (pending_events.size() > first) pending_events[$].event_last = 1'b1;
    endfunction

    task check_event(out_item_t got);
      out_item_t want;
      if (pending_events.size() == 0) begin
        report($sformatf("event with none due: id=%0d down=%0b last=%0b",
                         got.event_id, got.event_down, got.event_last));
        return;
      end
      want = pending_events.pop_front();
      events_seen++;
      if (got.event_id !== want.event_id)
        report($sformatf("event_id %0d, expected %0d", got.event_id, want.event_id));
      if (got.event_down !== want.event_down)
        report($sformatf("event_down %0b, expected %0b", got.event_down, want.event_down));
      if (got.event_last !== want.event_last)
        report($sformatf("event_last %0b, expected %0b", got.event_last, want.event_last));
    endtask

    function int pending();
      return pending_events.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  debounce_checker sb;
  int              cycle_count = 0;
  int              ticks_sent = 0;
  int              reg_writes = 0;
  int              burst_left = 0;
  int              holdoffs_asked = 0;
  int              holdoffs_served = 0;
  logic [3:0]      last_raw = 4'hF;

  four_button_debouncer u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Timed out after %0d cycles with %0d events outstanding",
               cycle_count, sb.pending());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Event monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_event(out_data);
  end

  // Receiver stall pattern, plus long hold-offs on demand
  int hold_left = 0;
  int mode_left = 0;
  int stall_mode = 0;
  always @(posedge clk) begin
    if (holdoffs_served != holdoffs_asked) begin
      holdoffs_served <= holdoffs_served + 1;
      hold_left <= HOLDOFF_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(40, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 9) < 6);
        default: out_stall <= ((mode_left % 8) < 3);
      endcase
    end
  end

  function automatic in_item_t tick_of(logic [3:0] lv, logic [7:0] ms);
    in_item_t t;
    t.raw_levels = lv;
    t.tick_ms = ms;
    return t;
  endfunction

  // Mostly steady levels with some bounce, occasional noise
  function automatic in_item_t random_tick(int unsigned max_ms);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) last_raw = 4'($urandom);
    else if (roll < 35) last_raw = last_raw ^ 4'($urandom_range(1, 15));
    if ($urandom_range(0, 9) == 0) return tick_of(last_raw, 8'($urandom));
    return tick_of(last_raw, 8'($urandom_range(0, max_ms)));
  endfunction

  // Offer one request and hold it until accepted; bursts separated by gaps
  task automatic offer_tick(in_item_t t);
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (in_stall);
    sb.note_tick(t);
    ticks_sent++;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  // Stop offering and wait until every due event has gone out
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write, then read back and compare (mapped registers only)
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    logic [31:0] got;
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk) cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, val);
    reg_writes++;
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk) cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    got = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    if (idx <= REG_BUTTON_ID3 && got !== sb.reg_value(idx))
      sb.report($sformatf("register %0d reads %0h, expected %0h", idx, got, sb.reg_value(idx)));
  endtask

  task automatic write_ids(logic [7:0] a, logic [7:0] b, logic [7:0] c, logic [7:0] d);
    write_reg(REG_BUTTON_ID0, {24'd0, a});
    write_reg(REG_BUTTON_ID1, {24'd0, b});
    write_reg(REG_BUTTON_ID2, {24'd0, c});
    write_reg(REG_BUTTON_ID3, {24'd0, d});
  endtask

  function automatic logic [7:0] random_id();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    int phase;
    int unsigned max_ms;
    logic [3:0] hold_lv;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Power-up settings: debounce 20 ms, active-low pins, all released
    offer_tick(tick_of(4'hF, 8'd0));
    offer_tick(tick_of(4'h0, 8'd255));    // all pressed, timers restart
    offer_tick(tick_of(4'h0, 8'd255));    // four presses from one tick
    offer_tick(tick_of(4'h5, 8'd10));
    offer_tick(tick_of(4'h5, 8'd19));     // one short of the debounce time
    offer_tick(tick_of(4'h5, 8'd1));      // reaches it exactly
    settle();

    // Zero debounce time: no event can ever fire
    write_reg(REG_DEBOUNCE, 32'd0);
    offer_tick(tick_of(4'hF, 8'd255));
    offer_tick(tick_of(4'hF, 8'd255));
    offer_tick(tick_of(4'hF, 8'd0));
    settle();

    // Debounce lowered beneath a running timer: it holds until a change
    write_reg(REG_DEBOUNCE, 32'd200);
    offer_tick(tick_of(4'h0, 8'd0));
    offer_tick(tick_of(4'h0, 8'd150));
    settle();
    write_reg(REG_DEBOUNCE, 32'd100);
    offer_tick(tick_of(4'h0, 8'd50));
    offer_tick(tick_of(4'h0, 8'd255));
    offer_tick(tick_of(4'h8, 8'd1));
    offer_tick(tick_of(4'h8, 8'd100));
    settle();

    // Polarity flip looks like a level change; extreme ids; spare indexes ignored
    write_reg(REG_DEBOUNCE, 32'd1);
    write_reg(REG_ACTIVE_LOW, 32'd0);
    write_ids(8'd255, 8'd0, 8'd128, 8'd1);
    write_reg(REG_SPARE6, $urandom);
    write_reg(REG_SPARE7, 32'hFFFF_FFFF);
    offer_tick(tick_of(4'h8, 8'd0));
    offer_tick(tick_of(4'h8, 8'd1));
    offer_tick(tick_of(4'h7, 8'd255));
    offer_tick(tick_of(4'h7, 8'd255));
    settle();

    // Longest debounce time: a steady hold of full ticks builds the timer
    // without reaching it
    write_reg(REG_DEBOUNCE, 32'h0000_FFFF);
    write_reg(REG_ACTIVE_LOW, 32'd1);
    hold_lv = sb.flipped_levels();
    repeat (20) offer_tick(tick_of(hold_lv, 8'd255));
    settle();

    // Random phases, each under its own settings
    phase = 0;
    while ((ticks_sent < 100 || sb.events_due < 40) && phase < 6) begin
      case (phase)
        0, 1: write_reg(REG_DEBOUNCE, 32'd1);
        default: begin
          case ($urandom_range(0, 4))
            0: write_reg(REG_DEBOUNCE, 32'd1);
            1: write_reg(REG_DEBOUNCE, 32'd255);
            default: write_reg(REG_DEBOUNCE, $urandom_range(2, 60));
          endcase
        end
      endcase
      write_reg(REG_ACTIVE_LOW, $urandom);
      write_ids(random_id(), random_id(), random_id(), random_id());
      max_ms = (sb.debounce_len / 2) + 1;
      if (max_ms > 255) max_ms = 255;
      // long receiver hold-off while ticks keep coming
      if (phase == 1) holdoffs_asked++;
      repeat (25) begin
        offer_tick(random_tick(max_ms));
        if ($urandom_range(0, 19) == 0) settle();
      end
      settle();
      phase++;
    end

    $display("Ran %0d ticks and %0d register writes over %0d random phases;",
             ticks_sent, reg_writes, phase);
    $display("%0d events checked, %0d receiver hold-offs, %0d mismatches",
             sb.events_seen, holdoffs_served, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
